// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define XTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define XTS_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) else $error(msg);
`else
`define XTS_ASSERT(lbl, clk, rstn, prop, msg)
`define XTS_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

// ===== rtl/core/xts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_pkg
// Shared types, register indexes and AES round functions.
// ----------------------------------------------------------------------------
package xts_pkg;

  localparam int SECTOR_BYTES_DEF = 512;
  localparam int NR = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DKEY_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DKEY_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TKEY_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TKEY_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd4;

  typedef logic [NR:0][127:0] rk_set_t;

  typedef struct packed {
    logic         idle;
    logic         dec;
  } ks_stat_t;

  typedef struct packed {
    logic [127:0] blk;
    logic [127:0] tweak;
    logic         last;
    logic         dec;
  } item_t;

  typedef struct packed {
    logic [127:0] res;
    logic         last;
  } res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int row = 0; row < 4; row++) begin
      for (int c = 0; c < 4; c++) begin
        t[row + 4*c] = SBOX[s[8*(row + 4*((c + row) & 3)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!fin) begin
        t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = t[i] ^ rk[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [1:0] sel);
    logic [7:0] x2, x4, x8;
    logic [7:0] r;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    unique case (sel)
      2'd0:    r = x8 ^ x4 ^ x2;
      2'd1:    r = x8 ^ x2 ^ a;
      2'd2:    r = x8 ^ x4 ^ a;
      default: r = x8 ^ a;
    endcase
    return r;
  endfunction

  localparam logic [1:0] M14 = 2'd0;
  localparam logic [1:0] M11 = 2'd1;
  localparam logic [1:0] M13 = 2'd2;
  localparam logic [1:0] M9  = 2'd3;

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int row = 0; row < 4; row++) begin
      for (int c = 0; c < 4; c++) begin
        t[row + 4*c] = ISBOX[s[8*(row + 4*((c + 4 - row) & 3)) +: 8]] ^
                       rk[8*(row + 4*c) +: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (mix) begin
        t[4*c]   = gm(a0, M14) ^ gm(a1, M11) ^ gm(a2, M13) ^ gm(a3, M9);
        t[4*c+1] = gm(a0, M9)  ^ gm(a1, M14) ^ gm(a2, M11) ^ gm(a3, M13);
        t[4*c+2] = gm(a0, M13) ^ gm(a1, M9)  ^ gm(a2, M14) ^ gm(a3, M11);
        t[4*c+3] = gm(a0, M11) ^ gm(a1, M13) ^ gm(a2, M9)  ^ gm(a3, M14);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = t[i];
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] p, input logic [7:0] rc);
    logic [31:0] w3, sr, n0, n1, n2, n3;
    w3 = p[127:96];
    sr = {SBOX[w3[7:0]], SBOX[w3[31:24]], SBOX[w3[23:16]], SBOX[w3[15:8]] ^ rc};
    n0 = p[31:0] ^ sr;
    n1 = p[63:32] ^ n0;
    n2 = p[95:64] ^ n1;
    n3 = p[127:96] ^ n2;
    return {n3, n2, n1, n0};
  endfunction

  function automatic logic [127:0] gf_dbl(input logic [127:0] t);
    return {t[126:0], 1'b0} ^ (t[127] ? 128'h87 : 128'h0);
  endfunction

endpackage

// ===== rtl/core/xts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_queue
// Small register FIFO with combinational head read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module xts_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= inc(wp_r);
      end
      if (pop) begin
        rp_r <= inc(rp_r);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  `XTS_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "queue overflow")
  `XTS_ASSERT(a_no_underflow, clk, rst_n, pop |-> !empty, "queue underflow")
  `XTS_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== rtl/core/xts_key_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_key_sched
// Key and mode registers; one-round-per-cycle key expansion into stores.
// ----------------------------------------------------------------------------
module xts_key_sched (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data,
  output xts_pkg::rk_set_t                rk_d,
  output xts_pkg::rk_set_t                rk_t,
  output xts_pkg::ks_stat_t               stat
);
  import xts_pkg::*;

  logic [127:0] key_d_r, key_t_r, prev_r;
  logic         dec_r, pend_d_r, pend_t_r, busy_r, sel_r;
  logic [3:0]   cnt_r;
  logic [7:0]   rc_r;
  rk_set_t      rk_d_r, rk_t_r;
  logic [127:0] nxt;

  assign cfg_ready = !busy_r && !pend_d_r && !pend_t_r;
  assign nxt       = key_next(prev_r, rc_r);
  assign rk_d      = rk_d_r;
  assign rk_t      = rk_t_r;
  assign stat.idle = cfg_ready;
  assign stat.dec  = dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_d_r  <= '0;
      key_t_r  <= '0;
      dec_r    <= 1'b0;
      pend_d_r <= 1'b1;
      pend_t_r <= 1'b1;
      busy_r   <= 1'b0;
      sel_r    <= 1'b0;
      cnt_r    <= '0;
      rc_r     <= 8'h01;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DKEY_LO: begin key_d_r[63:0]   <= cfg_data; pend_d_r <= 1'b1; end
          REG_DKEY_HI: begin key_d_r[127:64] <= cfg_data; pend_d_r <= 1'b1; end
          REG_TKEY_LO: begin key_t_r[63:0]   <= cfg_data; pend_t_r <= 1'b1; end
          REG_TKEY_HI: begin key_t_r[127:64] <= cfg_data; pend_t_r <= 1'b1; end
          REG_MODE:    dec_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (!busy_r && (pend_d_r || pend_t_r)) begin
        busy_r <= 1'b1;
        sel_r  <= !pend_d_r;
        cnt_r  <= 4'd1;
        rc_r   <= 8'h01;
        if (pend_d_r) begin
          pend_d_r <= 1'b0;
        end else begin
          pend_t_r <= 1'b0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        rc_r  <= xt(rc_r);
        if (cnt_r == 4'(NR)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && (pend_d_r || pend_t_r)) begin
      if (pend_d_r) begin
        rk_d_r[0] <= key_d_r;
        prev_r    <= key_d_r;
      end else begin
        rk_t_r[0] <= key_t_r;
        prev_r    <= key_t_r;
      end
    end else if (busy_r) begin
      prev_r <= nxt;
      if (sel_r) begin
        rk_t_r[cnt_r] <= nxt;
      end else begin
        rk_d_r[cnt_r] <= nxt;
      end
    end
  end

endmodule

// ===== rtl/core/xts_tweak_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_tweak_front
// Sector position tracking and pipelined tweak encryption with doubling.
// ----------------------------------------------------------------------------
module xts_tweak_front #(
  parameter int SECTOR_BYTES = xts_pkg::SECTOR_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [127:0]      blk,
  input  logic [63:0]       sector,
  input  xts_pkg::rk_set_t  rk_t,
  input  xts_pkg::ks_stat_t stat,
  output logic              q_push,
  output xts_pkg::item_t    q_item,
  input  logic              q_full
);
  import xts_pkg::*;

  localparam int BLOCKS = ((SECTOR_BYTES / 16) > 0) ? (SECTOR_BYTES / 16) : 1;
  localparam int PW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  logic [PW-1:0] pos_r;
  logic [NR:0]   v_r, first_r, last_r, dec_r;
  logic [127:0]  s_r   [NR+1];
  logic [127:0]  blk_r [NR+1];
  logic [127:0]  tw_r, tw_use;
  logic          en, acc, is_last;

  assign en      = !(v_r[NR] && q_full);
  assign in_full = !(en && stat.idle);
  assign acc     = in_push && !in_full;
  assign is_last = (pos_r == PW'(BLOCKS - 1));
  assign q_push  = v_r[NR] && !q_full;
  assign tw_use  = first_r[NR] ? s_r[NR] : tw_r;

  assign q_item.blk   = blk_r[NR];
  assign q_item.tweak = tw_use;
  assign q_item.last  = last_r[NR];
  assign q_item.dec   = dec_r[NR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      v_r   <= '0;
      tw_r  <= '0;
    end else begin
      if (acc) begin
        pos_r <= is_last ? '0 : pos_r + 1'b1;
      end
      if (en) begin
        v_r <= {v_r[NR-1:0], acc};
      end
      if (q_push) begin
        tw_r <= gf_dbl(tw_use);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]     <= {64'h0, sector} ^ rk_t[0];
      blk_r[0]   <= blk;
      first_r[0] <= (pos_r == '0);
      last_r[0]  <= is_last;
      dec_r[0]   <= stat.dec;
      for (int k = 1; k <= NR; k++) begin
        s_r[k]     <= enc_round(s_r[k-1], rk_t[k], 1'(k == NR));
        blk_r[k]   <= blk_r[k-1];
        first_r[k] <= first_r[k-1];
        last_r[k]  <= last_r[k-1];
        dec_r[k]   <= dec_r[k-1];
      end
    end
  end

endmodule

// ===== rtl/core/xts_data_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_data_back
// Pipelined AES-128 encrypt/decrypt of tweak-whitened data blocks.
// ----------------------------------------------------------------------------
module xts_data_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  xts_pkg::item_t   q_item,
  input  xts_pkg::rk_set_t rk_d,
  output logic             r_push,
  output xts_pkg::res_t    r_item,
  input  logic             r_full
);
  import xts_pkg::*;

  logic [NR:0]  v_r, last_r, dec_r;
  logic [127:0] s_r  [NR+1];
  logic [127:0] tw_r [NR+1];
  logic         en;

  assign en          = !(v_r[NR] && r_full);
  assign q_pop       = en && !q_empty;
  assign r_push      = v_r[NR] && !r_full;
  assign r_item.res  = s_r[NR] ^ tw_r[NR];
  assign r_item.last = last_r[NR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NR-1:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]    <= q_item.blk ^ q_item.tweak ^ (q_item.dec ? rk_d[NR] : rk_d[0]);
      tw_r[0]   <= q_item.tweak;
      last_r[0] <= q_item.last;
      dec_r[0]  <= q_item.dec;
      for (int k = 1; k <= NR; k++) begin
        s_r[k]    <= dec_r[k-1] ? dec_round(s_r[k-1], rk_d[NR-k], 1'(k != NR))
                                : enc_round(s_r[k-1], rk_d[k], 1'(k == NR));
        tw_r[k]   <= tw_r[k-1];
        last_r[k] <= last_r[k-1];
        dec_r[k]  <= dec_r[k-1];
      end
    end
  end

endmodule

// ===== rtl/core/aes_xts_sector_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_xts_sector_cipher
// AES-128-XTS sector cipher, one 128-bit block per cycle while nothing stalls.
// ----------------------------------------------------------------------------
// Input queue side: drive in_block_lo/hi and in_sector_number with in_push;
// a beat is taken when in_push is high and in_full is low. Blocks of a
// sector arrive in order; the sector number is used on the first block only.
// Result side: a result is shown while out_empty is low and taken with
// out_pop. out_sector_end marks the last block of a sector.
// Throughput is one block per cycle while nothing stalls, set by two 11-stage
// AES pipelines (tweak front, data back) joined by a 2-entry queue. A result
// passes front stages, middle queue, back stages and output queue, in order.
// When the receiver stalls, the back pipeline holds once its output queue is
// full, then the middle queue fills and in_full rises; nothing is dropped.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data. Each key write
// triggers a key expansion during which cfg_ready and in_full hold the block
// off. After reset both all-zero key schedules are expanded before the first
// beat is taken.
// ----------------------------------------------------------------------------
module aes_xts_sector_cipher #(
  parameter int SECTOR_BYTES = xts_pkg::SECTOR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [63:0]                   in_block_lo,
  input  logic [63:0]                   in_block_hi,
  input  logic [63:0]                   in_sector_number,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [63:0]                   out_lo,
  output logic [63:0]                   out_hi,
  output logic                          out_sector_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import xts_pkg::*;

  rk_set_t  rk_d, rk_t;
  ks_stat_t stat;
  item_t    f_item, b_item;
  res_t     r_in, r_out;
  logic     mq_push, mq_full, mq_pop, mq_empty;
  logic     oq_push, oq_full;

  xts_key_sched u_ks (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rk_d      (rk_d),
    .rk_t      (rk_t),
    .stat      (stat)
  );

  xts_tweak_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .blk     ({in_block_hi, in_block_lo}),
    .sector  (in_sector_number),
    .rk_t    (rk_t),
    .stat    (stat),
    .q_push  (mq_push),
    .q_item  (f_item),
    .q_full  (mq_full)
  );

  xts_queue #(.W($bits(item_t)), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (f_item),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (b_item),
    .empty (mq_empty)
  );

  xts_data_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mq_empty),
    .q_pop   (mq_pop),
    .q_item  (b_item),
    .rk_d    (rk_d),
    .r_push  (oq_push),
    .r_item  (r_in),
    .r_full  (oq_full)
  );

  xts_queue #(.W($bits(res_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (r_in),
    .full  (oq_full),
    .pop   (out_pop && !out_empty),
    .rdata (r_out),
    .empty (out_empty)
  );

  assign out_lo         = r_out.res[63:0];
  assign out_hi         = r_out.res[127:64];
  assign out_sector_end = r_out.last;

endmodule
